[rtl/vga_pkg.sv]
// ============================================================================
// vga_pkg: shared types and constants of the four-component vector ALU
// Fixed-point format, opcode and error codes, the transaction record that
// travels down the pipeline, and the saturation helper.
// ============================================================================
package vga_pkg;

   // fixed-point format and datapath sizes
   localparam int FRAC_BITS     = 16;
   localparam int DW            = 32;
   localparam int OP_W          = 4;
   localparam int TOL_W         = 16;
   localparam int ERR_W         = 2;
   localparam int LANES         = 4;
   localparam int MUL_CNT       = 8;
   localparam int PROD_W        = 2 * DW;
   localparam int FL_W          = PROD_W - FRAC_BITS;
   localparam int SAT_W         = PROD_W + 2;
   localparam int SQ_STEPS      = DW - 1;
   localparam int RAD_W         = 2 * SQ_STEPS;
   localparam int DIV_STEPS     = DW + FRAC_BITS;
   localparam int NORM_PRESHIFT = 2;

   localparam logic [TOL_W-1:0]      TOL_RESET = TOL_W'(7);
   localparam logic signed [DW-1:0]  MAX_VAL   = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0]  MIN_VAL   = {1'b1, {(DW-1){1'b0}}};
   localparam logic [DW-1:0]         ONE_VAL   = DW'(64'd1 << FRAC_BITS);
   localparam logic signed [SAT_W-1:0] SAT_HI  = SAT_W'(MAX_VAL);
   localparam logic signed [SAT_W-1:0] SAT_LO  = SAT_W'(MIN_VAL);
   localparam logic [PROD_W:0]       SQ_LIMIT  = (PROD_W+1)'(1) << RAD_W;

   // operation codes
   typedef enum logic [OP_W-1:0] {
      OP_ADD       = 4'd0,
      OP_SUB       = 4'd1,
      OP_NEG       = 4'd2,
      OP_SCALE     = 4'd3,
      OP_DIV       = 4'd4,
      OP_MAG       = 4'd5,
      OP_NORM      = 4'd6,
      OP_DOT       = 4'd7,
      OP_CROSS     = 4'd8,
      OP_EQ        = 4'd9,
      OP_IS_POINT  = 4'd10,
      OP_IS_VECTOR = 4'd11
   } op_type;

   // error codes
   localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
   localparam logic [ERR_W-1:0] ERR_DIV_ZERO = 2'd1;
   localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd2;

   // transaction record carried from the front end through the divider
   typedef struct packed {
      logic [OP_W-1:0]               op;
      logic [LANES-1:0][DW-1:0]      r;
      logic [DW-1:0]                 sc;
      logic                          flag;
      logic [ERR_W-1:0]              err;
      logic                          big;
      logic [LANES-1:0]              num_neg;
      logic [LANES-1:0][DW-1:0]      num_mag;
      logic                          den_neg;
      logic [DW-1:0]                 den;
   } item_type;

   typedef struct packed {
      logic [DW-1:0] val;
      logic          ovf;
   } sat_type;

   // clamp a wide signed value to the 32-bit range
   function automatic sat_type sat_word(input logic signed [SAT_W-1:0] v);
      sat_type s;
      if (v > SAT_HI) begin
         s.val = MAX_VAL;
         s.ovf = 1'b1;
      end else if (v < SAT_LO) begin
         s.val = MIN_VAL;
         s.ovf = 1'b1;
      end else begin
         s.val = v[DW-1:0];
         s.ovf = 1'b0;
      end
      return s;
   endfunction

endpackage

[rtl/vga_ifaces.sv]
// ============================================================================
// vga_ifaces: request and response channels of the vector ALU
// Valid/ready channels; a transaction moves when valid and ready are high.
// ============================================================================
interface vga_req_if;
   logic                           valid;
   logic                           ready;
   logic [vga_pkg::OP_W-1:0]       opcode;
   logic signed [vga_pkg::DW-1:0]  a_x;
   logic signed [vga_pkg::DW-1:0]  a_y;
   logic signed [vga_pkg::DW-1:0]  a_z;
   logic signed [vga_pkg::DW-1:0]  a_w;
   logic signed [vga_pkg::DW-1:0]  b_x;
   logic signed [vga_pkg::DW-1:0]  b_y;
   logic signed [vga_pkg::DW-1:0]  b_z;
   logic signed [vga_pkg::DW-1:0]  b_w;
   logic signed [vga_pkg::DW-1:0]  scalar_in;

   modport source (output valid, opcode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                   scalar_in, input ready);
   modport sink   (input valid, opcode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                   scalar_in, output ready);
endinterface

interface vga_rsp_if;
   logic                           valid;
   logic                           ready;
   logic signed [vga_pkg::DW-1:0]  r_x;
   logic signed [vga_pkg::DW-1:0]  r_y;
   logic signed [vga_pkg::DW-1:0]  r_z;
   logic signed [vga_pkg::DW-1:0]  r_w;
   logic signed [vga_pkg::DW-1:0]  scalar_out;
   logic                           test_flag;
   logic [vga_pkg::ERR_W-1:0]      error_code;

   modport source (output valid, r_x, r_y, r_z, r_w, scalar_out, test_flag,
                   error_code, input ready);
   modport sink   (input valid, r_x, r_y, r_z, r_w, scalar_out, test_flag,
                   error_code, output ready);
endinterface

[rtl/vec4_geometry_alu_core.sv]
// ============================================================================
// vec4_geometry_alu_core: pipelined four-component Q16.16 vector ALU
// Add, subtract, negate, scale, divide, magnitude, normalize, dot, cross,
// tolerance compare and point/vector tests with saturation and error codes.
// ============================================================================
// Usage:
//   req_bus carries one operation per transaction: opcode, tuples a and b,
//   and a scalar. rsp_bus returns one result per request, in order.
//   csr_write_data is the equality tolerance, written on csr_write_enable;
//   the user must write it only while no transaction is in flight (unchecked).
// Throughput: one transaction per clock, whatever the opcode, unless stalled.
// Pipeline: 84 register stages from the request to rsp_bus: input register,
//   multiply, two add/saturate stages, a 31-stage square-root pipe and a
//   48-stage divider (one bit per stage), then the output register. Every
//   opcode takes the full pipe.
// Reset: synchronous; clears all valid bits and sets the tolerance to 7.
// Stall: while a result waits with rsp_bus.ready low, the whole pipe holds
//   and req_bus.ready drops; nothing is lost or repeated.
// ============================================================================
module vec4_geometry_alu_core (
   input  logic                        clock,
   input  logic                        reset,
   vga_req_if.sink                     req_bus,
   vga_rsp_if.source                   rsp_bus,
   input  logic                        csr_write_enable,
   input  logic [vga_pkg::TOL_W-1:0]   csr_write_data
);

   typedef struct packed {
      logic [vga_pkg::OP_W-1:0]                   op;
      logic [vga_pkg::LANES-1:0][vga_pkg::DW-1:0] a;
      logic [vga_pkg::LANES-1:0][vga_pkg::DW-1:0] b;
      logic [vga_pkg::DW-1:0]                     s;
   } inp_type;

   typedef struct packed {
      logic [vga_pkg::LANES-1:0][vga_pkg::DW-1:0] r;
      logic                                       flag;
      logic                                       ovf;
   } simple_type;

   typedef struct packed {
      vga_pkg::item_type                item;
      logic [vga_pkg::RAD_W-1:0]        rad;
      logic [vga_pkg::SQ_STEPS-1:0]     root;
      logic [vga_pkg::SQ_STEPS+1:0]     rem;
   } sq_type;

   logic                              en;
   logic                              out_valid;
   vga_pkg::item_type                 out_item;
   logic [vga_pkg::TOL_W-1:0]         tol_ff;

   // stage 0: input register
   inp_type                           in0_in;
   inp_type                           in0_ff;
   logic                              v0_ff;

   // stage 1: products
   logic signed [vga_pkg::DW-1:0]     mul_a   [vga_pkg::MUL_CNT];
   logic signed [vga_pkg::DW-1:0]     mul_b   [vga_pkg::MUL_CNT];
   logic signed [vga_pkg::DW-1:0]     quarter0 [vga_pkg::LANES];
   logic signed [vga_pkg::PROD_W-1:0] prod_in  [vga_pkg::MUL_CNT];
   logic signed [vga_pkg::PROD_W-1:0] prod1_ff [vga_pkg::MUL_CNT];
   inp_type                           in1_ff;
   logic                              v1_ff;

   // stage 2: rounded products and partial sums
   logic signed [vga_pkg::FL_W-1:0]   fl_in  [vga_pkg::MUL_CNT];
   logic signed [vga_pkg::FL_W-1:0]   fl2_ff [vga_pkg::MUL_CNT];
   logic signed [vga_pkg::FL_W:0]     dlo_in, dhi_in, dlo_ff, dhi_ff;
   logic [vga_pkg::PROD_W-1:0]        sqlo_in, sqhi_in, sqlo_ff, sqhi_ff;
   logic [vga_pkg::PROD_W-1:0]        cqlo_in, cqhi_in, cqlo_ff, cqhi_ff;
   simple_type                        simple_in;
   simple_type                        simple_ff;
   inp_type                           in2_ff;
   logic                              v2_ff;

   // stage 3 and square-root pipe
   sq_type                            sq_in0;
   sq_type                            sq_next [vga_pkg::SQ_STEPS];
   sq_type                            sq_ff   [vga_pkg::SQ_STEPS+1];
   logic [vga_pkg::SQ_STEPS:0]        sqv_ff;
   vga_pkg::item_type                 hd_item;

   // hold the whole pipe while a result waits
   assign en            = !out_valid || rsp_bus.ready;
   assign req_bus.ready = en;

   // tolerance register
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= vga_pkg::TOL_RESET;
      end else if (csr_write_enable) begin
         tol_ff <= csr_write_data;
      end
   end

   // gather the request payload
   always_comb begin
      in0_in.op   = req_bus.opcode;
      in0_in.a[0] = req_bus.a_x;
      in0_in.a[1] = req_bus.a_y;
      in0_in.a[2] = req_bus.a_z;
      in0_in.a[3] = req_bus.a_w;
      in0_in.b[0] = req_bus.b_x;
      in0_in.b[1] = req_bus.b_y;
      in0_in.b[2] = req_bus.b_z;
      in0_in.b[3] = req_bus.b_w;
      in0_in.s    = req_bus.scalar_in;
   end

   // route multiplier operands by opcode
   always_comb begin
      for (int k = 0; k < vga_pkg::MUL_CNT; k++) begin
         mul_a[k] = '0;
         mul_b[k] = '0;
      end
      for (int i = 0; i < vga_pkg::LANES; i++) begin
         quarter0[i] = $signed(in0_ff.a[i]) >>> vga_pkg::NORM_PRESHIFT;
      end
      case (in0_ff.op) inside
         vga_pkg::OP_SCALE: begin
            for (int i = 0; i < vga_pkg::LANES; i++) begin
               mul_a[i] = $signed(in0_ff.a[i]);
               mul_b[i] = $signed(in0_ff.s);
            end
         end
         vga_pkg::OP_DOT: begin
            for (int i = 0; i < vga_pkg::LANES; i++) begin
               mul_a[i] = $signed(in0_ff.a[i]);
               mul_b[i] = $signed(in0_ff.b[i]);
            end
         end
         vga_pkg::OP_CROSS: begin
            mul_a[0] = $signed(in0_ff.a[1]);  mul_b[0] = $signed(in0_ff.b[2]);
            mul_a[1] = $signed(in0_ff.a[2]);  mul_b[1] = $signed(in0_ff.b[1]);
            mul_a[2] = $signed(in0_ff.a[2]);  mul_b[2] = $signed(in0_ff.b[0]);
            mul_a[3] = $signed(in0_ff.a[0]);  mul_b[3] = $signed(in0_ff.b[2]);
            mul_a[4] = $signed(in0_ff.a[0]);  mul_b[4] = $signed(in0_ff.b[1]);
            mul_a[5] = $signed(in0_ff.a[1]);  mul_b[5] = $signed(in0_ff.b[0]);
         end
         vga_pkg::OP_MAG, vga_pkg::OP_NORM: begin
            for (int i = 0; i < vga_pkg::LANES; i++) begin
               mul_a[i]                 = $signed(in0_ff.a[i]);
               mul_b[i]                 = $signed(in0_ff.a[i]);
               mul_a[i+vga_pkg::LANES]  = quarter0[i];
               mul_b[i+vga_pkg::LANES]  = quarter0[i];
            end
         end
         default: ;
      endcase
      for (int k = 0; k < vga_pkg::MUL_CNT; k++) begin
         prod_in[k] = mul_a[k] * mul_b[k];
      end
   end

   // round products toward minus infinity and form pair sums
   always_comb begin
      for (int k = 0; k < vga_pkg::MUL_CNT; k++) begin
         fl_in[k] = vga_pkg::FL_W'(prod1_ff[k] >>> vga_pkg::FRAC_BITS);
      end
      dlo_in  = (vga_pkg::FL_W+1)'(fl_in[0]) + (vga_pkg::FL_W+1)'(fl_in[1]);
      dhi_in  = (vga_pkg::FL_W+1)'(fl_in[2]) + (vga_pkg::FL_W+1)'(fl_in[3]);
      sqlo_in = $unsigned(prod1_ff[0]) + $unsigned(prod1_ff[1]);
      sqhi_in = $unsigned(prod1_ff[2]) + $unsigned(prod1_ff[3]);
      cqlo_in = $unsigned(prod1_ff[4]) + $unsigned(prod1_ff[5]);
      cqhi_in = $unsigned(prod1_ff[6]) + $unsigned(prod1_ff[7]);
   end

   // simple operations: add, subtract, negate, compares
   always_comb begin
      vga_pkg::sat_type            st;
      logic signed [vga_pkg::DW:0] diff;
      logic [vga_pkg::DW:0]        abs_diff;
      st        = '0;
      diff      = '0;
      abs_diff  = '0;
      simple_in = '0;
      case (in1_ff.op)
         vga_pkg::OP_ADD: begin
            for (int i = 0; i < vga_pkg::LANES; i++) begin
               st = vga_pkg::sat_word(vga_pkg::SAT_W'($signed(in1_ff.a[i])) +
                                      vga_pkg::SAT_W'($signed(in1_ff.b[i])));
               simple_in.r[i] = st.val;
               simple_in.ovf  = simple_in.ovf | st.ovf;
            end
         end
         vga_pkg::OP_SUB: begin
            for (int i = 0; i < vga_pkg::LANES; i++) begin
               st = vga_pkg::sat_word(vga_pkg::SAT_W'($signed(in1_ff.a[i])) -
                                      vga_pkg::SAT_W'($signed(in1_ff.b[i])));
               simple_in.r[i] = st.val;
               simple_in.ovf  = simple_in.ovf | st.ovf;
            end
         end
         vga_pkg::OP_NEG: begin
            for (int i = 0; i < vga_pkg::LANES; i++) begin
               st = vga_pkg::sat_word(-vga_pkg::SAT_W'($signed(in1_ff.a[i])));
               simple_in.r[i] = st.val;
               simple_in.ovf  = simple_in.ovf | st.ovf;
            end
         end
         vga_pkg::OP_EQ: begin
            simple_in.flag = 1'b1;
            for (int i = 0; i < vga_pkg::LANES; i++) begin
               diff = (vga_pkg::DW+1)'($signed(in1_ff.a[i])) -
                      (vga_pkg::DW+1)'($signed(in1_ff.b[i]));
               abs_diff = diff[vga_pkg::DW] ? $unsigned(-diff) : $unsigned(diff);
               if (abs_diff >= (vga_pkg::DW+1)'(tol_ff)) begin
                  simple_in.flag = 1'b0;
               end
            end
         end
         vga_pkg::OP_IS_POINT: begin
            simple_in.flag = (in1_ff.a[3] == vga_pkg::ONE_VAL);
         end
         vga_pkg::OP_IS_VECTOR: begin
            simple_in.flag = (in1_ff.a[3] == '0);
         end
         default: ;
      endcase
   end

   // final sums, saturation, and set-up of the root and divide operands
   always_comb begin
      vga_pkg::sat_type           st;
      logic                       ovf;
      logic                       big;
      logic [vga_pkg::PROD_W:0]   sq_tot;
      logic [vga_pkg::PROD_W-1:0] cq_tot;
      logic [vga_pkg::DW-1:0]     cv;
      st     = '0;
      ovf    = 1'b0;
      sq_tot = {1'b0, sqlo_ff} + {1'b0, sqhi_ff};
      cq_tot = cqlo_ff + cqhi_ff;
      big    = (sq_tot >= vga_pkg::SQ_LIMIT);
      cv     = '0;
      sq_in0 = '0;
      sq_in0.item.op = in2_ff.op;
      case (in2_ff.op) inside
         vga_pkg::OP_ADD, vga_pkg::OP_SUB, vga_pkg::OP_NEG, vga_pkg::OP_EQ,
         vga_pkg::OP_IS_POINT, vga_pkg::OP_IS_VECTOR: begin
            sq_in0.item.r    = simple_ff.r;
            sq_in0.item.flag = simple_ff.flag;
            ovf              = simple_ff.ovf;
         end
         vga_pkg::OP_SCALE: begin
            for (int i = 0; i < vga_pkg::LANES; i++) begin
               st = vga_pkg::sat_word(vga_pkg::SAT_W'(fl2_ff[i]));
               sq_in0.item.r[i] = st.val;
               ovf = ovf | st.ovf;
            end
         end
         vga_pkg::OP_DOT: begin
            st = vga_pkg::sat_word(vga_pkg::SAT_W'(dlo_ff) + vga_pkg::SAT_W'(dhi_ff));
            sq_in0.item.sc = st.val;
            ovf = st.ovf;
         end
         vga_pkg::OP_CROSS: begin
            for (int i = 0; i < vga_pkg::LANES - 1; i++) begin
               st = vga_pkg::sat_word(vga_pkg::SAT_W'(fl2_ff[2*i]) -
                                      vga_pkg::SAT_W'(fl2_ff[2*i+1]));
               sq_in0.item.r[i] = st.val;
               ovf = ovf | st.ovf;
            end
         end
         vga_pkg::OP_MAG: begin
            sq_in0.item.big = big;
            if (big) begin
               sq_in0.item.sc = vga_pkg::MAX_VAL;
               ovf = 1'b1;
            end else begin
               sq_in0.rad = sq_tot[vga_pkg::RAD_W-1:0];
            end
         end
         vga_pkg::OP_NORM: begin
            sq_in0.item.big = big;
            sq_in0.rad = big ? cq_tot[vga_pkg::RAD_W-1:0] : sq_tot[vga_pkg::RAD_W-1:0];
            for (int i = 0; i < vga_pkg::LANES; i++) begin
               cv = big ? vga_pkg::DW'($signed(in2_ff.a[i]) >>> vga_pkg::NORM_PRESHIFT)
                        : in2_ff.a[i];
               sq_in0.item.num_neg[i] = cv[vga_pkg::DW-1];
               sq_in0.item.num_mag[i] = cv[vga_pkg::DW-1] ? (~cv + 1'b1) : cv;
            end
         end
         vga_pkg::OP_DIV: begin
            for (int i = 0; i < vga_pkg::LANES; i++) begin
               sq_in0.item.num_neg[i] = in2_ff.a[i][vga_pkg::DW-1];
               sq_in0.item.num_mag[i] = in2_ff.a[i][vga_pkg::DW-1] ?
                                        (~in2_ff.a[i] + 1'b1) : in2_ff.a[i];
            end
            sq_in0.item.den_neg = in2_ff.s[vga_pkg::DW-1];
            sq_in0.item.den     = in2_ff.s[vga_pkg::DW-1] ? (~in2_ff.s + 1'b1) : in2_ff.s;
         end
         default: ;
      endcase
      sq_in0.item.err = ovf ? vga_pkg::ERR_OVERFLOW : vga_pkg::ERR_NONE;
   end

   // one root bit per stage: bring in two radicand bits, try subtract
   always_comb begin
      logic [vga_pkg::SQ_STEPS+3:0] shr;
      logic [vga_pkg::SQ_STEPS+3:0] trial;
      shr   = '0;
      trial = '0;
      for (int k = 0; k < vga_pkg::SQ_STEPS; k++) begin
         sq_next[k]     = sq_ff[k];
         shr            = {sq_ff[k].rem, sq_ff[k].rad[vga_pkg::RAD_W-1 -: 2]};
         trial          = (vga_pkg::SQ_STEPS+4)'({sq_ff[k].root, 2'b01});
         sq_next[k].rad = sq_ff[k].rad << 2;
         if (shr >= trial) begin
            sq_next[k].rem  = (vga_pkg::SQ_STEPS+2)'(shr - trial);
            sq_next[k].root = {sq_ff[k].root[vga_pkg::SQ_STEPS-2:0], 1'b1};
         end else begin
            sq_next[k].rem  = (vga_pkg::SQ_STEPS+2)'(shr);
            sq_next[k].root = {sq_ff[k].root[vga_pkg::SQ_STEPS-2:0], 1'b0};
         end
      end
   end

   // hand the root to magnitude or to the divider
   always_comb begin
      hd_item = sq_ff[vga_pkg::SQ_STEPS].item;
      if (hd_item.op == vga_pkg::OP_MAG && !hd_item.big) begin
         hd_item.sc = vga_pkg::DW'(sq_ff[vga_pkg::SQ_STEPS].root);
      end
      if (hd_item.op == vga_pkg::OP_NORM) begin
         hd_item.den     = vga_pkg::DW'(sq_ff[vga_pkg::SQ_STEPS].root);
         hd_item.den_neg = 1'b0;
      end
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff  <= 1'b0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         sqv_ff <= '0;
      end else if (en) begin
         v0_ff  <= req_bus.valid;
         v1_ff  <= v0_ff;
         v2_ff  <= v1_ff;
         sqv_ff <= {sqv_ff[vga_pkg::SQ_STEPS-1:0], v2_ff};
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         in0_ff    <= in0_in;
         in1_ff    <= in0_ff;
         in2_ff    <= in1_ff;
         for (int k = 0; k < vga_pkg::MUL_CNT; k++) begin
            prod1_ff[k] <= prod_in[k];
            fl2_ff[k]   <= fl_in[k];
         end
         dlo_ff    <= dlo_in;
         dhi_ff    <= dhi_in;
         sqlo_ff   <= sqlo_in;
         sqhi_ff   <= sqhi_in;
         cqlo_ff   <= cqlo_in;
         cqhi_ff   <= cqhi_in;
         simple_ff <= simple_in;
         sq_ff[0]  <= sq_in0;
         for (int k = 0; k < vga_pkg::SQ_STEPS; k++) begin
            sq_ff[k+1] <= sq_next[k];
         end
      end
   end

   vga_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sqv_ff[vga_pkg::SQ_STEPS]),
      .in_item   (hd_item),
      .out_valid (out_valid),
      .out_item  (out_item)
   );

   // drive the response channel
   assign rsp_bus.valid      = out_valid;
   assign rsp_bus.r_x        = out_item.r[0];
   assign rsp_bus.r_y        = out_item.r[1];
   assign rsp_bus.r_z        = out_item.r[2];
   assign rsp_bus.r_w        = out_item.r[3];
   assign rsp_bus.scalar_out = out_item.sc;
   assign rsp_bus.test_flag  = out_item.flag;
   assign rsp_bus.error_code = out_item.err;

endmodule

[rtl/vga_div_pipe.sv]
// ============================================================================
// vga_div_pipe: pipelined fixed-point divider and result stage
// One quotient bit per stage in four lanes sharing a divisor, then sign,
// saturation and divide-by-zero handling into the output register.
// ============================================================================
module vga_div_pipe (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  vga_pkg::item_type in_item,
   output logic              out_valid,
   output vga_pkg::item_type out_item
);

   typedef struct packed {
      vga_pkg::item_type                                         item;
      logic [vga_pkg::LANES-1:0][vga_pkg::DW-1:0]                rem;
      logic [vga_pkg::LANES-1:0][vga_pkg::DIV_STEPS-1:0]         nq;
   } dv_type;

   localparam logic [vga_pkg::DIV_STEPS-1:0] LIM_POS =
      vga_pkg::DIV_STEPS'(vga_pkg::MAX_VAL);
   localparam logic [vga_pkg::DIV_STEPS-1:0] LIM_NEG =
      vga_pkg::DIV_STEPS'(1) << (vga_pkg::DW - 1);

   dv_type                           st_src [vga_pkg::DIV_STEPS];
   dv_type                           st_in  [vga_pkg::DIV_STEPS];
   dv_type                           st_ff  [vga_pkg::DIV_STEPS];
   logic [vga_pkg::DIV_STEPS-1:0]    st_v_ff;
   vga_pkg::item_type                fin_in;
   vga_pkg::item_type                out_ff;
   logic                             out_valid_ff;

   // feed each stage from the previous one; the first from the input
   always_comb begin
      st_src[0].item = in_item;
      for (int i = 0; i < vga_pkg::LANES; i++) begin
         st_src[0].rem[i] = '0;
         st_src[0].nq[i]  = vga_pkg::DIV_STEPS'(in_item.num_mag[i]) << vga_pkg::FRAC_BITS;
      end
      for (int j = 1; j < vga_pkg::DIV_STEPS; j++) begin
         st_src[j] = st_ff[j-1];
      end
   end

   // one restoring step per stage: shift in a dividend bit, try subtract
   always_comb begin
      logic [vga_pkg::DW:0] t;
      t = '0;
      for (int j = 0; j < vga_pkg::DIV_STEPS; j++) begin
         st_in[j] = st_src[j];
         for (int i = 0; i < vga_pkg::LANES; i++) begin
            t = {st_src[j].rem[i], st_src[j].nq[i][vga_pkg::DIV_STEPS-1]};
            if (t >= {1'b0, st_src[j].item.den}) begin
               st_in[j].rem[i] = vga_pkg::DW'(t - {1'b0, st_src[j].item.den});
               st_in[j].nq[i]  = {st_src[j].nq[i][vga_pkg::DIV_STEPS-2:0], 1'b1};
            end else begin
               st_in[j].rem[i] = vga_pkg::DW'(t);
               st_in[j].nq[i]  = {st_src[j].nq[i][vga_pkg::DIV_STEPS-2:0], 1'b0};
            end
         end
      end
   end

   // apply sign, clamp, and flag divide by zero
   always_comb begin
      logic                          neg;
      logic                          ovf;
      logic [vga_pkg::DIV_STEPS-1:0] q;
      neg    = 1'b0;
      ovf    = 1'b0;
      q      = '0;
      fin_in = st_ff[vga_pkg::DIV_STEPS-1].item;
      if (fin_in.op == vga_pkg::OP_DIV || fin_in.op == vga_pkg::OP_NORM) begin
         fin_in.r = '0;
         if (fin_in.den == '0) begin
            fin_in.err = vga_pkg::ERR_DIV_ZERO;
         end else begin
            for (int i = 0; i < vga_pkg::LANES; i++) begin
               q   = st_ff[vga_pkg::DIV_STEPS-1].nq[i];
               neg = fin_in.num_neg[i] ^ fin_in.den_neg;
               if (neg) begin
                  if (q > LIM_NEG) begin
                     fin_in.r[i] = vga_pkg::MIN_VAL;
                     ovf = 1'b1;
                  end else begin
                     fin_in.r[i] = vga_pkg::DW'(~q + 1'b1);
                  end
               end else begin
                  if (q > LIM_POS) begin
                     fin_in.r[i] = vga_pkg::MAX_VAL;
                     ovf = 1'b1;
                  end else begin
                     fin_in.r[i] = vga_pkg::DW'(q);
                  end
               end
            end
            fin_in.err = ovf ? vga_pkg::ERR_OVERFLOW : vga_pkg::ERR_NONE;
         end
      end
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         st_v_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         st_v_ff      <= {st_v_ff[vga_pkg::DIV_STEPS-2:0], in_valid};
         out_valid_ff <= st_v_ff[vga_pkg::DIV_STEPS-1];
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < vga_pkg::DIV_STEPS; j++) begin
            st_ff[j] <= st_in[j];
         end
         out_ff <= fin_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_item  = out_ff;

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench of the four-component Q16.16 vector ALU core
// Drives operations through the valid/ready request channel with random gaps.
// A built-in predictor computes each expected result, and a checker compares
// every returned result, field by field, with the oldest expected one.
// The equality tolerance is swept across its range while the pipe is empty.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  CYCLE_LIMIT = 1_000_000;
   localparam int  DRAIN_WAIT  = 90;
   localparam longint Q_ONE    = longint'(1) << vga_pkg::FRAC_BITS;
   localparam longint W_MAX    = 64'sd2147483647;
   localparam longint W_MIN    = -64'sd2147483648;

   // one request transaction
   typedef struct {
      logic [vga_pkg::OP_W-1:0]      opcode;
      logic signed [vga_pkg::DW-1:0] a [vga_pkg::LANES];
      logic signed [vga_pkg::DW-1:0] b [vga_pkg::LANES];
      logic signed [vga_pkg::DW-1:0] scalar;
   } vec_req_type;

   // one response transaction
   typedef struct {
      logic [vga_pkg::DW-1:0]        r [vga_pkg::LANES];
      logic [vga_pkg::DW-1:0]        sc;
      logic                          flag;
      logic [vga_pkg::ERR_W-1:0]     err;
   } vec_rsp_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic [vga_pkg::TOL_W-1:0] csr_write_data;

   vga_req_if req_if ();
   vga_rsp_if rsp_if ();

   vec_rsp_type               pending_results [$];
   logic [vga_pkg::TOL_W-1:0] tolerance;
   int unsigned               fail_count = 0;
   int unsigned               cycle_count = 0;
   bit                        no_idle = 1'b0;
   int                        rsp_stall = 0;

   vec4_geometry_alu_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_if),
      .rsp_bus          (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------

   // clamp to the 32-bit signed range, flag overflow
   function automatic logic [vga_pkg::DW-1:0] clamp_word(input longint v, inout bit ovf);
      if (v > W_MAX) begin
         ovf = 1'b1;
         return W_MAX[vga_pkg::DW-1:0];
      end
      if (v < W_MIN) begin
         ovf = 1'b1;
         return W_MIN[vga_pkg::DW-1:0];
      end
      return v[vga_pkg::DW-1:0];
   endfunction

   // fixed-point product, rounded toward minus infinity
   function automatic longint fix_mul(input longint x, input longint y);
      return (x * y) >>> vga_pkg::FRAC_BITS;
   endfunction

   function automatic longint unsigned root_floor(input longint unsigned n);
      longint unsigned res = 0;
      longint unsigned pw = 64'd1 << 62;
      while (pw > n) pw >>= 2;
      while (pw != 0) begin
         if (n >= res + pw) begin
            n   = n - (res + pw);
            res = (res >> 1) + pw;
         end else begin
            res >>= 1;
         end
         pw >>= 2;
      end
      return res;
   endfunction

   // sum of squares, stops at 2^62
   function automatic longint unsigned square_sum(input longint c [vga_pkg::LANES],
                                                  output bit big);
      longint unsigned s = 0;
      longint unsigned m;
      big = 1'b0;
      for (int i = 0; i < vga_pkg::LANES; i++) begin
         m = (c[i] < 0) ? longint'(-c[i]) : longint'(c[i]);
         s = s + m * m;
         if (s >= (64'd1 << 62)) begin
            big = 1'b1;
            return 64'd1 << 62;
         end
      end
      return s;
   endfunction

   function automatic vec_rsp_type compute_vec_result(input vec_req_type q,
                                                      input logic [vga_pkg::TOL_W-1:0] tol);
      vec_rsp_type res;
      longint a [vga_pkg::LANES];
      longint b [vga_pkg::LANES];
      longint c [vga_pkg::LANES];
      longint s, m, d;
      longint unsigned sq;
      bit ovf = 1'b0;
      bit big;
      for (int i = 0; i < vga_pkg::LANES; i++) begin
         a[i]     = q.a[i];
         b[i]     = q.b[i];
         res.r[i] = '0;
      end
      s        = q.scalar;
      res.sc   = '0;
      res.flag = 1'b0;
      res.err  = vga_pkg::ERR_NONE;
      case (q.opcode)
         vga_pkg::OP_ADD:
            for (int i = 0; i < vga_pkg::LANES; i++) res.r[i] = clamp_word(a[i] + b[i], ovf);
         vga_pkg::OP_SUB:
            for (int i = 0; i < vga_pkg::LANES; i++) res.r[i] = clamp_word(a[i] - b[i], ovf);
         vga_pkg::OP_NEG:
            for (int i = 0; i < vga_pkg::LANES; i++) res.r[i] = clamp_word(-a[i], ovf);
         vga_pkg::OP_SCALE:
            for (int i = 0; i < vga_pkg::LANES; i++)
               res.r[i] = clamp_word(fix_mul(a[i], s), ovf);
         vga_pkg::OP_DIV: begin
            if (s == 0) res.err = vga_pkg::ERR_DIV_ZERO;
            else for (int i = 0; i < vga_pkg::LANES; i++)
               res.r[i] = clamp_word((a[i] * Q_ONE) / s, ovf);
         end
         vga_pkg::OP_MAG: begin
            sq = square_sum(a, big);
            if (big) begin
               res.sc = W_MAX[vga_pkg::DW-1:0];
               ovf    = 1'b1;
            end else begin
               m      = longint'(root_floor(sq));
               res.sc = m[vga_pkg::DW-1:0];
            end
         end
         vga_pkg::OP_NORM: begin
            sq = square_sum(a, big);
            for (int i = 0; i < vga_pkg::LANES; i++) c[i] = a[i];
            if (big) begin
               for (int i = 0; i < vga_pkg::LANES; i++) c[i] = c[i] >>> 2;
               sq = square_sum(c, big);
            end
            m = root_floor(sq);
            if (m == 0) res.err = vga_pkg::ERR_DIV_ZERO;
            else for (int i = 0; i < vga_pkg::LANES; i++)
               res.r[i] = clamp_word((c[i] * Q_ONE) / m, ovf);
         end
         vga_pkg::OP_DOT: res.sc = clamp_word(fix_mul(a[0], b[0]) + fix_mul(a[1], b[1]) +
                                              fix_mul(a[2], b[2]) + fix_mul(a[3], b[3]), ovf);
         vga_pkg::OP_CROSS: begin
            res.r[0] = clamp_word(fix_mul(a[1], b[2]) - fix_mul(a[2], b[1]), ovf);
            res.r[1] = clamp_word(fix_mul(a[2], b[0]) - fix_mul(a[0], b[2]), ovf);
            res.r[2] = clamp_word(fix_mul(a[0], b[1]) - fix_mul(a[1], b[0]), ovf);
         end
         vga_pkg::OP_EQ: begin
            res.flag = 1'b1;
            for (int i = 0; i < vga_pkg::LANES; i++) begin
               d = a[i] - b[i];
               if (d < 0) d = -d;
               if (d >= longint'(tol)) res.flag = 1'b0;
            end
         end
         vga_pkg::OP_IS_POINT:  res.flag = (a[3] == Q_ONE);
         vga_pkg::OP_IS_VECTOR: res.flag = (a[3] == 0);
         default: ;
      endcase
      if (ovf && res.err == vga_pkg::ERR_NONE) res.err = vga_pkg::ERR_OVERFLOW;
      return res;
   endfunction

   // ---------------------------------------------------------------------------
   // Response side: random stalls and checking
   // ---------------------------------------------------------------------------

   function automatic int gap_length();
      int pick;
      if (no_idle) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // hold ready low for random stretches
   always @(posedge clock) begin
      if (rsp_stall > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_stall    <= rsp_stall - 1;
      end else begin
         rsp_if.ready <= 1'b1;
         rsp_stall    <= gap_length();
      end
   end

   function automatic void compare_field(input string name, input longint want,
                                         input longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d (0x%0h), actual %0d (0x%0h)",
                name, want, want, got, got);
         fail_count++;
      end
   endfunction

   // compare each returned transaction with the oldest expected one
   always @(posedge clock) begin
      vec_rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected response transaction");
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            compare_field("r_x", signed'(want.r[0]), rsp_if.r_x);
            compare_field("r_y", signed'(want.r[1]), rsp_if.r_y);
            compare_field("r_z", signed'(want.r[2]), rsp_if.r_z);
            compare_field("r_w", signed'(want.r[3]), rsp_if.r_w);
            compare_field("scalar_out", signed'(want.sc), rsp_if.scalar_out);
            compare_field("test_flag", want.flag, rsp_if.test_flag);
            compare_field("error_code", want.err, rsp_if.error_code);
         end
      end
   end

   // stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------

   task automatic send_item(input vec_req_type q);
      int gap;
      req_if.valid     <= 1'b1;
      req_if.opcode    <= q.opcode;
      req_if.a_x       <= q.a[0];
      req_if.a_y       <= q.a[1];
      req_if.a_z       <= q.a[2];
      req_if.a_w       <= q.a[3];
      req_if.b_x       <= q.b[0];
      req_if.b_y       <= q.b[1];
      req_if.b_z       <= q.b[2];
      req_if.b_w       <= q.b[3];
      req_if.scalar_in <= q.scalar;
      do @(posedge clock); while (!req_if.ready);
      pending_results.push_back(compute_vec_result(q, tolerance));
      gap = gap_length();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // wait until every expected transaction has returned
   task automatic drain();
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_tolerance(input logic [vga_pkg::TOL_W-1:0] value);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tolerance = value;
   endtask

   function automatic vec_req_type make_req(input logic [vga_pkg::OP_W-1:0] op,
      input longint ax, input longint ay, input longint az, input longint aw,
      input longint bx, input longint by, input longint bz, input longint bw,
      input longint s);
      vec_req_type q;
      q.opcode = op;
      q.a[0] = ax[vga_pkg::DW-1:0]; q.a[1] = ay[vga_pkg::DW-1:0];
      q.a[2] = az[vga_pkg::DW-1:0]; q.a[3] = aw[vga_pkg::DW-1:0];
      q.b[0] = bx[vga_pkg::DW-1:0]; q.b[1] = by[vga_pkg::DW-1:0];
      q.b[2] = bz[vga_pkg::DW-1:0]; q.b[3] = bw[vga_pkg::DW-1:0];
      q.scalar = s[vga_pkg::DW-1:0];
      return q;
   endfunction

   // operand value: full random, small, extreme or mid-sized
   function automatic logic signed [vga_pkg::DW-1:0] rand_word();
      case ($urandom_range(0, 5))
         0, 1: return $urandom();
         2: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
         3: case ($urandom_range(0, 5))
               0: return W_MAX[vga_pkg::DW-1:0];
               1: return W_MIN[vga_pkg::DW-1:0];
               2: return 0;
               3: return -1;
               4: return Q_ONE[vga_pkg::DW-1:0];
               default: return 1;
            endcase
         4: return $signed($urandom_range(0, 1 << 26)) - (1 << 25);
         default: return $signed($urandom_range(0, 1 << 12)) - (1 << 11);
      endcase
   endfunction

   function automatic vec_req_type rand_req();
      vec_req_type q;
      int delta;
      q.opcode = ($urandom_range(0, 19) == 0) ? vga_pkg::OP_W'($urandom_range(12, 15))
                                              : vga_pkg::OP_W'($urandom_range(0, 11));
      for (int i = 0; i < vga_pkg::LANES; i++) begin
         q.a[i] = rand_word();
         q.b[i] = rand_word();
      end
      q.scalar = rand_word();
      case (q.opcode) inside
         // keep b close to a so the tolerance decides
         vga_pkg::OP_EQ: if ($urandom_range(0, 3) != 0)
            for (int i = 0; i < vga_pkg::LANES; i++) begin
               delta  = $urandom_range(0, 2 * int'(tolerance) + 4) - (int'(tolerance) + 2);
               q.b[i] = q.a[i] + delta;
            end
         vga_pkg::OP_IS_POINT, vga_pkg::OP_IS_VECTOR: case ($urandom_range(0, 2))
            0: q.a[3] = Q_ONE[vga_pkg::DW-1:0];
            1: q.a[3] = 0;
            default: ;
         endcase
         vga_pkg::OP_DIV: if ($urandom_range(0, 9) == 0) q.scalar = 0;
         vga_pkg::OP_NORM: if ($urandom_range(0, 9) == 0)
            for (int i = 0; i < vga_pkg::LANES; i++) q.a[i] = 0;
         default: ;
      endcase
      return q;
   endfunction

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // saturation on add, sub, neg, scale, div and dot
   task automatic test_saturation();
      send_item(make_req(vga_pkg::OP_ADD, W_MAX, W_MIN, 1, -1, W_MAX, W_MIN, 2, -2, 0));
      send_item(make_req(vga_pkg::OP_SUB, W_MIN, W_MAX, 0, 5, W_MAX, W_MIN, 0, 3, 0));
      send_item(make_req(vga_pkg::OP_NEG, W_MIN, W_MAX, 0, -1, 0, 0, 0, 0, 0));
      send_item(make_req(vga_pkg::OP_SCALE, W_MAX, W_MIN, -3, 3, 0, 0, 0, 0, W_MAX));
      send_item(make_req(vga_pkg::OP_SCALE, -1, 1, -Q_ONE, 3 * Q_ONE, 0, 0, 0, 0, 1));
      send_item(make_req(vga_pkg::OP_DIV, W_MAX, W_MIN, Q_ONE, -Q_ONE, 0, 0, 0, 0, 1));
      send_item(make_req(vga_pkg::OP_DIV, W_MIN, 7, -7, Q_ONE, 0, 0, 0, 0, -1));
      send_item(make_req(vga_pkg::OP_DOT, W_MAX, W_MAX, W_MAX, W_MAX,
                         W_MAX, W_MAX, W_MAX, W_MAX, 0));
      send_item(make_req(vga_pkg::OP_DOT, W_MIN, W_MIN, 0, 0, W_MAX, W_MAX, 0, 0, 0));
   endtask

   // division by zero, magnitude limits, normalize corner cases, cross
   task automatic test_special_cases();
      send_item(make_req(vga_pkg::OP_DIV, Q_ONE, 2, 3, 4, 0, 0, 0, 0, 0));
      send_item(make_req(vga_pkg::OP_MAG, 3 * Q_ONE, 4 * Q_ONE, 0, 0, 0, 0, 0, 0, 0));
      send_item(make_req(vga_pkg::OP_MAG, W_MAX, W_MIN, W_MAX, W_MIN, 0, 0, 0, 0, 0));
      send_item(make_req(vga_pkg::OP_NORM, 0, 0, 0, 0, 1, 1, 1, 1, 1));
      send_item(make_req(vga_pkg::OP_NORM, W_MAX, W_MIN, W_MAX, W_MIN, 0, 0, 0, 0, 0));
      send_item(make_req(vga_pkg::OP_NORM, 3 * Q_ONE, -4 * Q_ONE, 0, 0, 0, 0, 0, 0, 0));
      send_item(make_req(vga_pkg::OP_NORM, 0, 0, 0, 1, 0, 0, 0, 0, 0));
      send_item(make_req(vga_pkg::OP_CROSS, Q_ONE, 0, 0, 9, 0, Q_ONE, 0, 9, 0));
      send_item(make_req(vga_pkg::OP_CROSS, W_MAX, W_MIN, W_MAX, 0,
                         W_MIN, W_MAX, W_MIN, 0, 0));
   endtask

   // equality at the tolerance edge, point and vector tests, unknown opcodes
   task automatic test_flags();
      send_item(make_req(vga_pkg::OP_EQ, 100, 200, 300, 400, 106, 194, 300, 400, 0));
      send_item(make_req(vga_pkg::OP_EQ, 100, 200, 300, 400, 107, 200, 300, 400, 0));
      send_item(make_req(vga_pkg::OP_EQ, W_MAX, 0, 0, 0, W_MIN, 0, 0, 0, 0));
      send_item(make_req(vga_pkg::OP_IS_POINT, 0, 0, 0, Q_ONE, 0, 0, 0, 0, 0));
      send_item(make_req(vga_pkg::OP_IS_POINT, 0, 0, 0, Q_ONE + 1, 0, 0, 0, 0, 0));
      send_item(make_req(vga_pkg::OP_IS_VECTOR, 5, 5, 5, 0, 0, 0, 0, 0, 0));
      send_item(make_req(vga_pkg::OP_IS_VECTOR, 5, 5, 5, -1, 0, 0, 0, 0, 0));
      for (int op = 12; op < 16; op++)
         send_item(make_req(vga_pkg::OP_W'(op), W_MAX, 1, 2, 3, W_MIN, 4, 5, 6, 0));
   endtask

   // random traffic under a sweep of tolerance settings
   task automatic test_random_sweep();
      logic [vga_pkg::TOL_W-1:0] settings [5];
      settings = '{16'd0, 16'hFFFF, 16'd1, 16'(Q_ONE >> 4), vga_pkg::TOL_RESET};
      foreach (settings[k]) begin
         write_tolerance(settings[k]);
         for (int n = 0; n < 350; n++) begin
            no_idle = (n >= 100 && n < 160);
            send_item(rand_req());
         end
         no_idle = 1'b0;
      end
   endtask

   initial begin
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      req_if.valid     <= 1'b0;
      req_if.opcode    <= '0;
      req_if.a_x       <= '0;
      req_if.a_y       <= '0;
      req_if.a_z       <= '0;
      req_if.a_w       <= '0;
      req_if.b_x       <= '0;
      req_if.b_y       <= '0;
      req_if.b_z       <= '0;
      req_if.b_w       <= '0;
      req_if.scalar_in <= '0;
      tolerance        = vga_pkg::TOL_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_saturation();
      test_special_cases();
      test_flags();
      test_random_sweep();
      drain();

      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
